// ===== design/rfaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfaf_pkg
// Shared constants and controller/datapath interface types for the receive
// frame address filter.
// ----------------------------------------------------------------------------
package rfaf_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int HDR_BYTES       = 7;
    localparam int POS_W           = 9;
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 16;
    localparam int M_DATA_W        = 72;

    localparam logic [2:0] POS_LEN     = 3'd0;
    localparam logic [2:0] POS_CTL_HI  = 3'd1;
    localparam logic [2:0] POS_CTL_LO  = 3'd2;
    localparam logic [2:0] POS_DST_HI  = 3'd3;
    localparam logic [2:0] POS_DST_LO  = 3'd4;
    localparam logic [2:0] POS_SRC_HI  = 3'd5;
    localparam logic [2:0] POS_SRC_LO  = 3'd6;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic take;
        logic read;
        logic cmp;
        logic emit;
    } rfaf_cmd_t;

    typedef struct packed {
        logic hdr_end;
        logic scan_end;
        logic hit;
        logic out_free;
    } rfaf_status_t;

endpackage
`default_nettype wire

// ===== design/rx_frame_address_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rx_frame_address_filter_unit
// Receive deframer with destination address filter and source address
// learning.
//
// Channel   Direction  Transaction
// s_*       in         one received byte
// m_*       out        one header summary or one passed payload byte
// cfg_*     in         write of the own address
//
// The last header byte waits for a scan of the learned sources, because the
// table is scanned one entry per read and compare pair through a single read
// port, and the scan stops at the first hit.
// Reset clears the position, the flags and the table fill count; no clearing
// pass is needed. A stalled output holds further intake once a result waits.
// ----------------------------------------------------------------------------
module rx_frame_address_filter_unit #(
    parameter int TABLE_DEPTH = rfaf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rx_byte [7:0]
    input  wire logic [rfaf_pkg::BYTE_W-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // frame_length [7:0], control_high [15:8], control_low [23:16],
    // destination [39:24], source [55:40], address_match [56],
    // source_new [57], table_full [58], payload_byte [66:59], zero [71:67]
    output logic [rfaf_pkg::M_DATA_W-1:0]          m_tdata,
    // kind [0]
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [rfaf_pkg::ADDR_W-1:0]       cfg_wdata
);

    rfaf_pkg::rfaf_cmd_t    cmd;
    rfaf_pkg::rfaf_status_t status;

    rfaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rfaf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .rx_byte   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

// ===== design/rfaf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfaf_ctrl
// Controller: sequences byte intake, the learned-source table scan and the
// issue of the header result.
// ----------------------------------------------------------------------------
module rfaf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire rfaf_pkg::rfaf_status_t status,
    output rfaf_pkg::rfaf_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = status.out_free;
                if (s_tvalid && status.out_free)
                begin
                    cmd.take = 1'b1;
                    if (status.hdr_end)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = status.hit ? ST_EMIT : ST_READ;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rfaf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfaf_datapath
// Datapath: header registers, byte position, learned-source table with its
// scan pointer, destination compare and the output register.
// ----------------------------------------------------------------------------
module rfaf_datapath #(
    parameter int TABLE_DEPTH = rfaf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire rfaf_pkg::rfaf_cmd_t               cmd,
    output rfaf_pkg::rfaf_status_t                 status,
    input  wire logic [rfaf_pkg::BYTE_W-1:0]       rx_byte,
    input  wire logic                              cfg_we,
    input  wire logic [rfaf_pkg::ADDR_W-1:0]       cfg_wdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rfaf_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW    = rfaf_pkg::POS_W;

    logic [rfaf_pkg::ADDR_W-1:0] own_addr_reg;
    logic [PW-1:0]               pos_reg;
    logic [rfaf_pkg::BYTE_W-1:0] len_reg;
    logic [rfaf_pkg::ADDR_W-1:0] ctl_reg;
    logic [rfaf_pkg::ADDR_W-1:0] dst_reg;
    logic [rfaf_pkg::ADDR_W-1:0] src_reg;
    logic                        accept_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        found_reg;
    logic [rfaf_pkg::ADDR_W-1:0] rd_data_reg;

    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [rfaf_pkg::BYTE_W-1:0] out_len_reg;
    logic [rfaf_pkg::ADDR_W-1:0] out_ctl_reg;
    logic [rfaf_pkg::ADDR_W-1:0] out_dst_reg;
    logic [rfaf_pkg::ADDR_W-1:0] out_src_reg;
    logic                        out_match_reg;
    logic                        out_new_reg;
    logic                        out_full_reg;
    logic [rfaf_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_last_reg;

    logic [rfaf_pkg::ADDR_W-1:0] table_mem [TABLE_DEPTH];

    logic          in_header;
    logic          final_byte;
    logic          room;
    logic          fresh;
    logic          full;
    logic          match;
    logic [PW:0]   frame_end;

    assign in_header  = pos_reg < PW'(rfaf_pkg::HDR_BYTES);
    assign frame_end  = (PW + 1)'(rfaf_pkg::HDR_BYTES) + {2'b00, len_reg};
    assign final_byte = ({1'b0, pos_reg} + (PW + 1)'(1)) >= frame_end;
    assign room       = count_reg < CNT_W'(TABLE_DEPTH);
    assign fresh      = !found_reg && room;
    assign full       = !found_reg && !room;
    assign match      = dst_reg == own_addr_reg;

    assign status.hdr_end  = pos_reg == PW'(rfaf_pkg::HDR_BYTES - 1);
    assign status.scan_end = idx_reg == count_reg;
    assign status.hit      = rd_data_reg == src_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.emit && fresh)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= src_reg;
        end
        if (cmd.read)
        begin
            rd_data_reg <= table_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            ctl_reg      <= '0;
            dst_reg      <= '0;
            src_reg      <= '0;
            accept_reg   <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                own_addr_reg <= cfg_wdata;
            end
            if (cmd.take)
            begin
                if (in_header)
                begin
                    unique case (pos_reg[2:0])
                        rfaf_pkg::POS_LEN:    len_reg        <= rx_byte;
                        rfaf_pkg::POS_CTL_HI: ctl_reg[15:8]  <= rx_byte;
                        rfaf_pkg::POS_CTL_LO: ctl_reg[7:0]   <= rx_byte;
                        rfaf_pkg::POS_DST_HI: dst_reg[15:8]  <= rx_byte;
                        rfaf_pkg::POS_DST_LO: dst_reg[7:0]   <= rx_byte;
                        rfaf_pkg::POS_SRC_HI: src_reg[15:8]  <= rx_byte;
                        rfaf_pkg::POS_SRC_LO: src_reg[7:0]   <= rx_byte;
                        default:              ;
                    endcase
                    if (status.hdr_end)
                    begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + PW'(1);
                    end
                end
                else
                begin
                    pos_reg <= final_byte ? '0 : pos_reg + PW'(1);
                end
            end
            if (cmd.cmp)
            begin
                if (status.hit)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                if (fresh)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                accept_reg <= match;
                pos_reg    <= (len_reg == '0) ? '0 : PW'(rfaf_pkg::HDR_BYTES);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || (cmd.take && !in_header && accept_reg))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg  <= rfaf_pkg::KIND_HEADER;
            out_len_reg   <= len_reg;
            out_ctl_reg   <= ctl_reg;
            out_dst_reg   <= dst_reg;
            out_src_reg   <= src_reg;
            out_match_reg <= match;
            out_new_reg   <= fresh;
            out_full_reg  <= full;
            out_byte_reg  <= '0;
            out_last_reg  <= match && (len_reg == '0);
        end
        else if (cmd.take && !in_header && accept_reg)
        begin
            out_kind_reg  <= rfaf_pkg::KIND_PAYLOAD;
            out_len_reg   <= len_reg;
            out_ctl_reg   <= ctl_reg;
            out_dst_reg   <= dst_reg;
            out_src_reg   <= src_reg;
            out_match_reg <= 1'b1;
            out_new_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
            out_byte_reg  <= rx_byte;
            out_last_reg  <= final_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_byte_reg, out_full_reg, out_new_reg, out_match_reg,
                       out_src_reg, out_dst_reg, out_ctl_reg[7:0], out_ctl_reg[15:8],
                       out_len_reg};

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the receive frame address filter. Byte streams of
// complete frames are sent into the slave side. The expected header summaries
// and passed payload bytes are predicted from the frame contents, the learned
// source table and the own address. They are then compared with the master
// side transactions in order. Both sides idle at random, the receiver holds
// off once for a long stretch, and the own address changes between phases,
// sometimes in the middle of a frame.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SCAN_SLACK   = 2 * rfaf_pkg::TABLE_DEPTH_DEF + 3 + 16;
    localparam int PHASE_ITEMS  = 320;
    localparam int NUM_PHASES   = 6;
    localparam int POOL_SIZE    = 20;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  payload_byte;
        logic        table_full;
        logic        source_new;
        logic        address_match;
        logic [15:0] src_addr;
        logic [15:0] dst_addr;
        logic [7:0]  control_low;
        logic [7:0]  control_high;
        logic [7:0]  frame_length;
    } frame_fields_t;

    typedef struct packed {
        logic          kind;
        logic          last;
        frame_fields_t f;
    } filter_result_t;

    class frame_filter_scoreboard;
        logic [15:0]    own_addr;
        logic [8:0]     position;
        logic [7:0]     len_q;
        logic [15:0]    ctl_q;
        logic [15:0]    dst_q;
        logic [15:0]    src_q;
        logic           accept_q;
        logic [15:0]    learned_src [rfaf_pkg::TABLE_DEPTH_DEF];
        int unsigned    learned_cnt;
        filter_result_t expected_q [$];
        int unsigned    mismatches;

        function new();
            own_addr    = 16'h0000;
            position    = 9'd0;
            len_q       = 8'h00;
            ctl_q       = 16'h0000;
            dst_q       = 16'h0000;
            src_q       = 16'h0000;
            accept_q    = 1'b0;
            learned_cnt = 0;
            mismatches  = 0;
        endfunction

        function filter_result_t make_result(logic kind, logic fresh, logic full,
                                             logic [7:0] pbyte, logic last);
            filter_result_t r;
            r                  = '0;
            r.kind             = kind;
            r.last             = last;
            r.f.frame_length   = len_q;
            r.f.control_high   = ctl_q[15:8];
            r.f.control_low    = ctl_q[7:0];
            r.f.dst_addr       = dst_q;
            r.f.src_addr       = src_q;
            r.f.address_match  = accept_q;
            r.f.source_new     = fresh;
            r.f.table_full     = full;
            r.f.payload_byte   = pbyte;
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            int unsigned k;
            bit          found;
            bit          fresh;
            bit          full;
            bit          final_byte;
            if (position < rfaf_pkg::HDR_BYTES)
            begin
                case (position[2:0])
                    rfaf_pkg::POS_LEN:    len_q       = b;
                    rfaf_pkg::POS_CTL_HI: ctl_q[15:8] = b;
                    rfaf_pkg::POS_CTL_LO: ctl_q[7:0]  = b;
                    rfaf_pkg::POS_DST_HI: dst_q[15:8] = b;
                    rfaf_pkg::POS_DST_LO: dst_q[7:0]  = b;
                    rfaf_pkg::POS_SRC_HI: src_q[15:8] = b;
                    default:              src_q[7:0]  = b;
                endcase
                if (position < rfaf_pkg::HDR_BYTES - 1)
                begin
                    position = position + 9'd1;
                end
                else
                begin
                    found = 1'b0;
                    fresh = 1'b0;
                    full  = 1'b0;
                    for (k = 0; k < learned_cnt; k++)
                    begin
                        if (learned_src[k] == src_q)
                            found = 1'b1;
                    end
                    if (!found)
                    begin
                        if (learned_cnt < rfaf_pkg::TABLE_DEPTH_DEF)
                        begin
                            learned_src[learned_cnt] = src_q;
                            learned_cnt++;
                            fresh = 1'b1;
                        end
                        else
                        begin
                            full = 1'b1;
                        end
                    end
                    accept_q = (dst_q == own_addr);
                    position = (len_q == 8'h00) ? 9'd0 : 9'(rfaf_pkg::HDR_BYTES);
                    expected_q.push_back(make_result(rfaf_pkg::KIND_HEADER, fresh, full,
                                                     8'h00,
                                                     accept_q && (len_q == 8'h00)));
                end
            end
            else
            begin
                final_byte = (int'(position) + 1 >= rfaf_pkg::HDR_BYTES + int'(len_q));
                position   = final_byte ? 9'd0 : position + 9'd1;
                if (accept_q)
                    expected_q.push_back(make_result(rfaf_pkg::KIND_PAYLOAD, 1'b0, 1'b0,
                                                     b, final_byte));
            end
        endfunction

        function string describe(filter_result_t r);
            return $sformatf({"kind=%0d len=%02h ctl=%02h%02h dst=%04h src=%04h ",
                              "match=%0d new=%0d full=%0d byte=%02h last=%0d pad=%02h"},
                             r.kind, r.f.frame_length, r.f.control_high, r.f.control_low,
                             r.f.dst_addr, r.f.src_addr, r.f.address_match,
                             r.f.source_new, r.f.table_full, r.f.payload_byte, r.last,
                             r.f.pad);
        endfunction

        function void check_result(filter_result_t got);
            filter_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result, nothing pending: %s", describe(got));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Result mismatch, expected %s", describe(want));
                    $display("                 actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    frame_filter_scoreboard filter_sb;
    logic [7:0]             pending_bytes [$];
    logic [15:0]            source_pool [POOL_SIZE];
    logic [15:0]            own_now;
    bit                     quiet;
    bit                     long_hold_req;
    int unsigned            sent_items;
    int unsigned            cycle_count;

    rx_frame_address_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function void push_header(logic [7:0] len, logic [7:0] chi, logic [7:0] clo,
                              logic [15:0] dst, logic [15:0] src);
        pending_bytes.push_back(len);
        pending_bytes.push_back(chi);
        pending_bytes.push_back(clo);
        pending_bytes.push_back(dst[15:8]);
        pending_bytes.push_back(dst[7:0]);
        pending_bytes.push_back(src[15:8]);
        pending_bytes.push_back(src[7:0]);
    endfunction

    function void push_random_frame();
        int          r;
        int          i;
        logic [7:0]  len;
        logic [15:0] dst;
        logic [15:0] src;
        r = $urandom_range(0, 99);
        if (r < 3)
            len = 8'hFF;
        else if (r < 8)
            len = 8'($urandom_range(0, 255));
        else if (r < 20)
            len = 8'h00;
        else
            len = 8'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 50)
            dst = own_now;
        else if (r < 65)
            dst = 16'($urandom_range(0, 65535));
        else
            dst = own_now ^ (16'h0001 << $urandom_range(0, 15));
        if ($urandom_range(0, 99) < 60)
            src = source_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            src = 16'($urandom_range(0, 65535));
        push_header(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), dst, src);
        for (i = 0; i < int'(len); i++)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        filter_sb.note_byte(b);
        sent_items++;
        if (!quiet && (sent_items % 256) < 160 && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic send_next();
        if (pending_bytes.size() == 0)
            push_random_frame();
        send_byte(pending_bytes.pop_front());
    endtask

    task automatic write_own(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        filter_sb.own_addr = value;
        own_now            = value;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (filter_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SCAN_SLACK) @(posedge clk);
    endtask

    initial
    begin
        int             stall_left;
        bit             hold_done;
        filter_result_t got;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                got.last = m_tlast;
                got.f    = m_tdata;
                filter_sb.check_result(got);
            end
            if (long_hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && (cycle_count % 512) < 320
                     && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rx_frame_address_filter_unit test failed");
        $finish;
    end

    initial
    begin
        int          ph;
        int          n;
        logic [15:0] phase_own [NUM_PHASES];
        filter_sb     = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'h0000;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        sent_items    = 0;
        own_now       = 16'h0000;
        for (n = 0; n < POOL_SIZE; n++)
            source_pool[n] = 16'($urandom_range(0, 65535));
        phase_own[0] = 16'hFFFF;
        phase_own[1] = 16'($urandom_range(0, 65535));
        phase_own[2] = 16'h0000;
        phase_own[3] = 16'($urandom_range(0, 65535));
        phase_own[4] = 16'hFFFF;
        phase_own[5] = 16'($urandom_range(0, 65535));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_own(16'h0000);

        // Accepted empty frame, rejected frame from a known source, then an
        // accepted frame with payload extremes.
        push_header(8'd0, 8'hFF, 8'h00, 16'h0000, 16'hFFFF);
        push_header(8'd2, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_header(8'd3, 8'hA5, 8'h5A, 16'h0000, 16'h0000);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h5A);
        while (pending_bytes.size() != 0)
            send_byte(pending_bytes.pop_front());
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_own(phase_own[ph]);
            if (ph == 1)
                long_hold_req = 1'b1;
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_next();
            drain();
        end

        if (filter_sb.mismatches == 0 && filter_sb.expected_q.size() == 0)
            $display("rx_frame_address_filter_unit test passed");
        else
            $display("rx_frame_address_filter_unit test failed");
        $finish;
    end

endmodule
